@@ hdl/trp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package trp_pkg;

    localparam int TRP_QUEUE_DEPTH = 4;
    localparam int SUB_DEPTH = 4;

    localparam logic [7:0] B_IAC  = 8'hff;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_LF   = 8'd10;
    localparam logic [7:0] B_NUL  = 8'd0;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] TT_SEND   = 8'd1;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    // work codes handed from front to back
    localparam logic [2:0] OP_NONE         = 3'd0;
    localparam logic [2:0] OP_DATA         = 3'd1;
    localparam logic [2:0] OP_CONNECT      = 3'd2;
    localparam logic [2:0] OP_SEND_TT      = 3'd3;
    localparam logic [2:0] OP_SEND_TT_INIT = 3'd4;
    localparam logic [2:0] OP_SEND_NAWS    = 3'd5;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       chunk_end;
    } trp_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        echo;
        logic [15:0] win_width;
        logic [15:0] win_height;
        logic        chunk_done;
        logic        last;
    } trp_out_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
        logic        echo;
        logic [15:0] win_width;
        logic [15:0] win_height;
        logic        chunk_end;
    } trp_desc_t;

    function automatic logic [3:0] reply_len(input logic [2:0] op);
        logic [3:0] n;
        case (op)
            OP_CONNECT:      n = 4'd3;
            OP_SEND_TT:      n = 4'd6;
            OP_SEND_NAWS:    n = 4'd6;
            OP_SEND_TT_INIT: n = 4'd15;
            default:         n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [2:0] op, input logic [3:0] idx);
        logic [7:0] opt;
        logic [7:0] b;
        opt = (op == OP_SEND_NAWS) ? OPT_NAWS : OPT_TTYPE;
        if (op == OP_CONNECT) begin
            case (idx)
                4'd0:    b = B_IAC;
                4'd1:    b = B_DO;
                default: b = OPT_TTYPE;
            endcase
        end
        else begin
            case (idx)
                4'd0:    b = B_IAC;
                4'd1:    b = B_SB;
                4'd2:    b = opt;
                4'd3:    b = TT_SEND;
                4'd4:    b = B_IAC;
                4'd5:    b = B_SE;
                4'd6:    b = B_IAC;
                4'd7:    b = B_WILL;
                4'd8:    b = OPT_ECHO;
                4'd9:    b = B_IAC;
                4'd10:   b = B_WILL;
                4'd11:   b = OPT_SGA;
                4'd12:   b = B_IAC;
                4'd13:   b = B_DO;
                default: b = OPT_NAWS;
            endcase
        end
        return b;
    endfunction

endpackage
`default_nettype wire

@@ hdl/telnet_receive_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An item's results pass through the descriptor queue and the output register.
// Throughput: one item per cycle when each item gives one result and pop stays
// high; a reply of n results (3, 6 or 15) holds the output sequencer for all n.
// The descriptor queue (QUEUE_DEPTH entries) absorbs bursts behind long replies.
// Reset (rst_n low, async): parser state, window size, echo flag and queue cleared.
module telnet_receive_parser_unit
    import trp_pkg::*;
#(
    parameter int QUEUE_DEPTH = TRP_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire trp_in_t  item,
    output logic          empty,
    input  wire logic     pop,
    output trp_out_t      result,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data
);

    trp_desc_t desc;
    trp_desc_t head;
    logic      accept;
    logic      head_valid;
    logic      head_done;

    assign cfg_ready = 1'b1;
    assign accept = push && !full;

    trp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .desc     (desc)
    );

    trp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (desc),
        .rd_en   (head_done),
        .rd_data (head),
        .q_full  (full),
        .q_valid (head_valid)
    );

    trp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_done  (head_done),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule
`default_nettype wire

@@ hdl/trp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module trp_front
    import trp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire trp_in_t   item,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    output trp_desc_t      desc
);

    localparam logic [2:0] S_NORMAL = 3'd0;
    localparam logic [2:0] S_CR     = 3'd1;
    localparam logic [2:0] S_IAC    = 3'd2;
    localparam logic [2:0] S_OPT    = 3'd3;
    localparam logic [2:0] S_SUB    = 3'd4;
    localparam logic [2:0] S_SUBIAC = 3'd5;
    localparam logic [2:0] SUB_FULL = 3'(SUB_DEPTH);

    logic [2:0]  state_reg, state_next;
    logic [7:0]  opt_reg, opt_next;
    logic        expl_reg, expl_next;
    logic [7:0]  sub_reg [SUB_DEPTH];
    logic [7:0]  sub_next [SUB_DEPTH];
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] ww_reg, ww_next;
    logic [15:0] wh_reg, wh_next;
    logic        echo_reg;
    logic [2:0]  op;
    logic [7:0]  data;

    always_comb
    begin
        logic [7:0] b;
        logic [2:0] c;
        b = item.rx_byte;
        c = cnt_reg;
        state_next = state_reg;
        opt_next = opt_reg;
        expl_next = expl_reg;
        sub_next = sub_reg;
        cnt_next = cnt_reg;
        ww_next = ww_reg;
        wh_next = wh_reg;
        op = OP_NONE;
        data = '0;
        if (item.func) begin
            op = OP_CONNECT;
        end
        else begin
            case (state_reg)
                S_CR:
                begin
                    op = OP_DATA;
                    data = (b == B_NUL) ? B_LF : b;
                    state_next = S_NORMAL;
                end
                S_IAC:
                begin
                    if (b == B_IAC) begin
                        op = OP_DATA;
                        data = B_IAC;
                        state_next = S_NORMAL;
                    end
                    else if (b >= B_SE) begin
                        opt_next = b;
                        state_next = S_OPT;
                    end
                    else begin
                        state_next = S_NORMAL;
                    end
                end
                S_OPT:
                begin
                    if (opt_reg == B_SB) begin
                        opt_next = b;
                        cnt_next = '0;
                        state_next = S_SUB;
                    end
                    else begin
                        state_next = S_NORMAL;
                        if (opt_reg == B_WILL && b == OPT_TTYPE) begin
                            op = expl_reg ? OP_SEND_TT : OP_SEND_TT_INIT;
                            expl_next = 1'b1;
                        end
                        else if (opt_reg == B_WILL && b == OPT_NAWS) begin
                            op = OP_SEND_NAWS;
                        end
                    end
                end
                S_SUB:
                begin
                    if (b == B_IAC) begin
                        state_next = S_SUBIAC;
                    end
                    else if (cnt_reg < SUB_FULL) begin
                        sub_next[cnt_reg[1:0]] = b;
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                S_SUBIAC:
                begin
                    if (b == B_SE) begin
                        if (opt_reg == OPT_NAWS && cnt_reg == SUB_FULL) begin
                            ww_next = {sub_reg[0], sub_reg[1]};
                            wh_next = {sub_reg[2], sub_reg[3]};
                        end
                        cnt_next = '0;
                        state_next = S_NORMAL;
                    end
                    else begin
                        if (b != B_IAC && c < SUB_FULL) begin
                            sub_next[c[1:0]] = B_IAC;
                            c = c + 3'd1;
                        end
                        if (c < SUB_FULL) begin
                            sub_next[c[1:0]] = b;
                            c = c + 3'd1;
                        end
                        cnt_next = c;
                        state_next = S_SUB;
                    end
                end
                default:
                begin
                    state_next = S_NORMAL;
                    if (b == B_IAC) begin
                        state_next = S_IAC;
                    end
                    else if (b == B_CR) begin
                        op = OP_DATA;
                        data = B_CR;
                        state_next = S_CR;
                    end
                    else if (b < B_SE) begin
                        op = OP_DATA;
                        data = b;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        desc.op = op;
        desc.data = data;
        desc.echo = echo_reg;
        desc.win_width = ww_next;
        desc.win_height = wh_next;
        desc.chunk_end = item.chunk_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_NORMAL;
            opt_reg <= '0;
            expl_reg <= 1'b0;
            cnt_reg <= '0;
            ww_reg <= '0;
            wh_reg <= '0;
            echo_reg <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                echo_reg <= cfg_data;
            end
            if (accept) begin
                state_reg <= state_next;
                opt_reg <= opt_next;
                expl_reg <= expl_next;
                cnt_reg <= cnt_next;
                ww_reg <= ww_next;
                wh_reg <= wh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            sub_reg <= sub_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/trp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module trp_queue
    import trp_pkg::*;
#(
    parameter int DEPTH = TRP_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire trp_desc_t wr_data,
    input  wire logic      rd_en,
    output trp_desc_t      rd_data,
    output logic           q_full,
    output logic           q_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    trp_desc_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign q_full = (cnt_reg == FULL_CNT);
    assign q_valid = (cnt_reg != '0);
    assign do_wr = wr_en && !q_full;
    assign do_rd = rd_en && q_valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/trp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module trp_back
    import trp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire trp_desc_t head,
    input  wire logic      head_valid,
    output logic           head_done,
    input  wire logic      pop,
    output logic           empty,
    output trp_out_t       result
);

    logic [3:0] idx_reg;
    logic       out_valid_reg;
    trp_out_t   out_reg;
    trp_out_t   gen;
    logic       load;
    logic       is_last;

    assign load = head_valid && (!out_valid_reg || pop);
    assign is_last = (idx_reg == reply_len(head.op) - 4'd1);
    assign head_done = load && is_last;
    assign empty = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        gen.win_width = head.win_width;
        gen.win_height = head.win_height;
        gen.last = is_last;
        gen.chunk_done = is_last && head.chunk_end;
        gen.echo = 1'b0;
        case (head.op)
            OP_NONE:
            begin
                gen.kind = KIND_NONE;
                gen.out_byte = '0;
            end
            OP_DATA:
            begin
                gen.kind = KIND_DATA;
                gen.out_byte = head.data;
                gen.echo = head.echo;
            end
            default:
            begin
                gen.kind = KIND_REPLY;
                gen.out_byte = reply_byte(head.op, idx_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg <= is_last ? 4'd0 : idx_reg + 4'd1;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= gen;
        end
    end

endmodule
`default_nettype wire

@@ hdl/trp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module trp_checker
    import trp_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     full,
    input wire logic     empty,
    input wire logic     pop,
    input wire trp_out_t result
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queue not empty in reset");

    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.kind == KIND_NONE |-> result.last && result.out_byte == 8'd0)
        else $error("empty result not final or nonzero");

    a_echo_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.echo |-> result.kind == KIND_DATA)
        else $error("echo on non-data result");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.chunk_done |-> result.last)
        else $error("chunk mark on non-final result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while stalled");

endmodule

bind telnet_receive_parser_unit trp_checker u_chk (.*);
`default_nettype wire

@@ test/trp_checker.sv @@
`timescale 1ns / 1ps
module trp_scoreboard
    import trp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire logic     full,
    input  wire trp_in_t  item,
    input  wire logic     empty,
    input  wire logic     pop,
    input  wire trp_out_t result,
    input  wire logic     cfg_valid,
    input  wire logic     cfg_ready,
    input  wire logic     cfg_data,
    output int            fail_count,
    output int            outstanding,
    output int            checked_count
);

    typedef enum logic [2:0] {
        PS_NORMAL,
        PS_CR,
        PS_IAC,
        PS_OPT,
        PS_SUB,
        PS_SUBIAC
    } parse_e;

    parse_e      pstate = PS_NORMAL;
    logic [7:0]  cur_opt = '0;
    logic        tt_done = 1'b0;
    logic [7:0]  sub_buf [SUB_DEPTH];
    int          sub_len = 0;
    logic [15:0] cols = '0;
    logic [15:0] rows = '0;
    logic        echo_on = 1'b0;
    trp_out_t    expected_q [$];
    trp_out_t    batch [$];
    int          errors = 0;
    int          n_checked = 0;

    initial
    begin
        fail_count = 0;
        outstanding = 0;
        checked_count = 0;
    end

    function automatic void emit(input logic [1:0] k, input logic [7:0] b);
        trp_out_t r;
        r = '0;
        r.kind = k;
        r.out_byte = (k == KIND_NONE) ? 8'd0 : b;
        r.echo = (k == KIND_DATA) ? echo_on : 1'b0;
        batch = {batch, r};
    endfunction

    function automatic void emit_reply3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        emit(KIND_REPLY, a);
        emit(KIND_REPLY, b);
        emit(KIND_REPLY, c);
    endfunction

    function automatic void emit_request(input logic [7:0] opt);
        emit_reply3(B_IAC, B_SB, opt);
        emit_reply3(TT_SEND, B_IAC, B_SE);
    endfunction

    function automatic void sub_keep(input logic [7:0] b);
        if (sub_len < SUB_DEPTH)
        begin
            sub_buf[sub_len] = b;
            sub_len++;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        case (pstate)
            PS_CR:
            begin
                emit(KIND_DATA, (b == B_NUL) ? B_LF : b);
                pstate = PS_NORMAL;
            end
            PS_IAC:
            begin
                if (b == B_IAC)
                begin
                    emit(KIND_DATA, B_IAC);
                    pstate = PS_NORMAL;
                end
                else if (b >= B_SE)
                begin
                    cur_opt = b;
                    pstate = PS_OPT;
                end
                else
                    pstate = PS_NORMAL;
            end
            PS_OPT:
            begin
                if (cur_opt == B_SB)
                begin
                    cur_opt = b;
                    sub_len = 0;
                    pstate = PS_SUB;
                end
                else
                begin
                    if (cur_opt == B_WILL && b == OPT_TTYPE)
                    begin
                        emit_request(OPT_TTYPE);
                        if (!tt_done)
                        begin
                            emit_reply3(B_IAC, B_WILL, OPT_ECHO);
                            emit_reply3(B_IAC, B_WILL, OPT_SGA);
                            emit_reply3(B_IAC, B_DO, OPT_NAWS);
                            tt_done = 1'b1;
                        end
                    end
                    else if (cur_opt == B_WILL && b == OPT_NAWS)
                        emit_request(OPT_NAWS);
                    pstate = PS_NORMAL;
                end
            end
            PS_SUB:
            begin
                if (b == B_IAC)
                    pstate = PS_SUBIAC;
                else
                    sub_keep(b);
            end
            PS_SUBIAC:
            begin
                if (b == B_SE)
                begin
                    if (cur_opt == OPT_NAWS && sub_len == SUB_DEPTH)
                    begin
                        cols = {sub_buf[0], sub_buf[1]};
                        rows = {sub_buf[2], sub_buf[3]};
                    end
                    sub_len = 0;
                    pstate = PS_NORMAL;
                end
                else
                begin
                    if (b != B_IAC)
                        sub_keep(B_IAC);
                    sub_keep(b);
                    pstate = PS_SUB;
                end
            end
            default:
            begin
                if (b == B_IAC)
                    pstate = PS_IAC;
                else if (b == B_CR)
                begin
                    emit(KIND_DATA, B_CR);
                    pstate = PS_CR;
                end
                else
                begin
                    if (b < B_SE)
                        emit(KIND_DATA, b);
                    pstate = PS_NORMAL;
                end
            end
        endcase
    endfunction

    function automatic void predict_item(input trp_in_t it);
        trp_out_t r;
        batch.delete();
        if (it.func)
            emit_reply3(B_IAC, B_DO, OPT_TTYPE);
        else
            parse_byte(it.rx_byte);
        if (batch.size() == 0)
            emit(KIND_NONE, 8'd0);
        foreach (batch[k])
        begin
            r = batch[k];
            r.win_width = cols;
            r.win_height = rows;
            r.last = (k == batch.size() - 1);
            r.chunk_done = r.last & it.chunk_end;
            expected_q = {expected_q, r};
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        trp_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                echo_on = cfg_data;
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h, expected none", $time, result);
                end
                else
                begin
                    want = expected_q.pop_front();
                    n_checked++;
                    check_field("kind", want.kind, result.kind);
                    check_field("out_byte", want.out_byte, result.out_byte);
                    check_field("echo", want.echo, result.echo);
                    check_field("win_width", want.win_width, result.win_width);
                    check_field("win_height", want.win_height, result.win_height);
                    check_field("chunk_done", want.chunk_done, result.chunk_done);
                    check_field("last", want.last, result.last);
                end
            end
            if (push && !full)
                predict_item(item);
            fail_count <= errors;
            outstanding <= expected_q.size();
            checked_count <= n_checked;
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import trp_pkg::*;

    typedef enum int {
        SEQ_DATA,
        SEQ_CR,
        SEQ_IAC_IAC,
        SEQ_SHORT_CMD,
        SEQ_OPTION,
        SEQ_WILL,
        SEQ_NAWS,
        SEQ_OTHER_SUB,
        SEQ_CONNECT,
        SEQ_NOISE
    } seq_e;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    trp_in_t  item = '0;
    logic     empty;
    logic     pop = 1'b0;
    trp_out_t result;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data = 1'b0;

    int fail_count;
    int outstanding;
    int checked_count;
    bit idling_on = 1'b1;
    int rx_hold = 0;
    int items_sent = 0;

    always #5 clk = ~clk;

    telnet_receive_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    trp_scoreboard u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    // receiver: random stalls, plus a counted hold-off when requested
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else
                pop <= !(idling_on && $urandom_range(99) < 26);
        end
    end

    task automatic send(input logic func, input logic [7:0] b);
        trp_in_t v;
        v.func = func;
        v.rx_byte = b;
        v.chunk_end = ($urandom_range(5) == 0);
        while (idling_on && $urandom_range(99) < 26)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= v;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    task automatic send_sub_byte(input logic [7:0] b);
        send(1'b0, b);
        if (b == B_IAC)
            send(1'b0, B_IAC);
    endtask

    task automatic send_will(input logic [7:0] opt);
        send(1'b0, B_IAC);
        send(1'b0, B_WILL);
        send(1'b0, opt);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_echo(input logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sequence();
        int roll;
        int n;
        bit extreme;
        logic [7:0] b;
        seq_e s;
        roll = $urandom_range(99);
        if (roll < 22) s = SEQ_DATA;
        else if (roll < 30) s = SEQ_CR;
        else if (roll < 35) s = SEQ_IAC_IAC;
        else if (roll < 40) s = SEQ_SHORT_CMD;
        else if (roll < 50) s = SEQ_OPTION;
        else if (roll < 58) s = SEQ_WILL;
        else if (roll < 80) s = SEQ_NAWS;
        else if (roll < 86) s = SEQ_OTHER_SUB;
        else if (roll < 90) s = SEQ_CONNECT;
        else s = SEQ_NOISE;
        case (s)
            SEQ_DATA:
                send(1'b0, 8'($urandom_range(254)));
            SEQ_CR:
            begin
                send(1'b0, B_CR);
                send(1'b0, $urandom_range(1) ? B_NUL : 8'($urandom_range(255)));
            end
            SEQ_IAC_IAC:
            begin
                send(1'b0, B_IAC);
                send(1'b0, B_IAC);
            end
            SEQ_SHORT_CMD:
            begin
                send(1'b0, B_IAC);
                send(1'b0, 8'($urandom_range(239)));
            end
            SEQ_OPTION:
            begin
                b = 8'($urandom_range(240, 254));
                if (b == B_SB)
                    b = B_DO;
                send(1'b0, B_IAC);
                send(1'b0, b);
                case ($urandom_range(2))
                    0: send(1'b0, OPT_TTYPE);
                    1: send(1'b0, OPT_NAWS);
                    default: send(1'b0, 8'($urandom_range(255)));
                endcase
            end
            SEQ_WILL:
                send_will($urandom_range(1) ? OPT_TTYPE : OPT_NAWS);
            SEQ_NAWS:
            begin
                send(1'b0, B_IAC);
                send(1'b0, B_SB);
                send(1'b0, OPT_NAWS);
                n = ($urandom_range(3) == 0) ? $urandom_range(6) : SUB_DEPTH;
                extreme = ($urandom_range(3) == 0);
                for (int i = 0; i < n; i++)
                begin
                    if (extreme)
                        b = (i < 2) ? B_IAC : 8'd0;
                    else
                        case ($urandom_range(3))
                            0: b = 8'd0;
                            1: b = B_IAC;
                            default: b = 8'($urandom_range(255));
                        endcase
                    if ($urandom_range(11) == 0)
                    begin
                        send(1'b0, B_IAC);
                        send(1'b0, 8'($urandom_range(241, 254)));
                    end
                    send_sub_byte(b);
                end
                send(1'b0, B_IAC);
                send(1'b0, B_SE);
            end
            SEQ_OTHER_SUB:
            begin
                send(1'b0, B_IAC);
                send(1'b0, B_SB);
                send(1'b0, $urandom_range(1) ? OPT_TTYPE : 8'($urandom_range(255)));
                n = $urandom_range(5);
                for (int i = 0; i < n; i++)
                    send_sub_byte(8'($urandom_range(255)));
                send(1'b0, B_IAC);
                send(1'b0, B_SE);
            end
            SEQ_CONNECT:
                send(1'b1, 8'($urandom_range(255)));
            default:
                send(1'b0, 8'($urandom_range(255)));
        endcase
    endtask

    initial
    begin
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_echo(1'b1);

        send(1'b1, 8'($urandom_range(255)));
        send(1'b0, 8'd0);
        send(1'b0, 8'd239);
        send(1'b0, B_SE);
        send(1'b0, 8'd254);
        send(1'b0, B_CR);
        send(1'b0, B_NUL);
        send(1'b0, B_CR);
        send(1'b0, B_IAC);
        send(1'b0, B_IAC);
        send(1'b0, B_IAC);
        send(1'b0, B_IAC);
        send(1'b0, 8'd5);
        send(1'b0, B_IAC);
        send(1'b0, B_DO);
        send(1'b0, OPT_ECHO);
        send_will(OPT_TTYPE);
        send_will(OPT_NAWS);

        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            write_echo(phase[0]);
            idling_on = (phase != 2);
            if (phase == 1)
            begin
                rx_hold = 60;
                send_will(OPT_TTYPE);
                send_will(OPT_NAWS);
            end
            while (items_sent < 30 + (phase + 1) * 45)
                send_sequence();
        end
        idling_on = 1'b1;
        settle();

        $display("Covered %0d items and %0d checked results under both echo settings,",
                 items_sent, checked_count);
        $display("with a receiver hold-off that backed the queue up into the input.");
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
